// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL.
// Define ASSERT_OFF to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== rtl/ihrg_pkg.sv =====
`default_nettype none

package ihrg_pkg;

   localparam int MAX_SITES   = 16;
   localparam int MAX_BONDS   = 16;
   localparam int STATE_W     = 16;
   localparam int SITE_W      = 4;
   localparam int COUNT_W     = 5;
   localparam int VALUE_W     = 37;
   localparam int COEF_W      = 6;
   localparam int PROD_W      = COEF_W + 32;
   localparam int TABLE_W     = 64;
   localparam int CSR_ADDR_W  = 6;
   localparam int CSR_DATA_W  = 64;
   localparam int RSP_DATA_W  = 64;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [2:0] {
      REG_NUM_SITES  = 3'd0,
      REG_BOND_COUNT = 3'd1,
      REG_BOND_LOW   = 3'd2,
      REG_BOND_HIGH  = 3'd3,
      REG_COUPLING_J = 3'd4,
      REG_FIELD_H    = 3'd5,
      REG_BOUNDARY   = 3'd6
   } reg_index_type;

   typedef struct packed {
      logic [COUNT_W-1:0]  num_sites;
      logic [COUNT_W-1:0]  bond_count;
      logic [TABLE_W-1:0]  bond_table_low;
      logic [TABLE_W-1:0]  bond_table_high;
      logic signed [31:0]  coupling_j;
      logic signed [31:0]  field_h;
      logic                boundary_field_on;
   } cfg_type;

   // One row job handed from the front to the back.
   typedef struct packed {
      logic [STATE_W-1:0]        state;
      logic [STATE_W-1:0]        pending;
      logic signed [VALUE_W-1:0] diag;
      logic [COUNT_W-1:0]        count;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

endpackage

`default_nettype wire

// ===== rtl/ihrg_csr.sv =====
`default_nettype none

module ihrg_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [ihrg_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [ihrg_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [ihrg_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                               csr_pready,
   output ihrg_pkg::cfg_type                  cfg
);

   ihrg_pkg::cfg_type       cfg_ff;
   ihrg_pkg::reg_index_type index;
   logic                    write_en;

   assign csr_pready = 1'b1;
   assign write_en   = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign index      = ihrg_pkg::reg_index_type'(csr_paddr[5:3]);
   assign cfg        = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.num_sites         <= 5'd16;
         cfg_ff.bond_count        <= '0;
         cfg_ff.bond_table_low    <= '0;
         cfg_ff.bond_table_high   <= '0;
         cfg_ff.coupling_j        <= 32'sd65536;
         cfg_ff.field_h           <= '0;
         cfg_ff.boundary_field_on <= 1'b0;
      end else if (write_en) begin
         unique case (index)
            ihrg_pkg::REG_NUM_SITES:  cfg_ff.num_sites  <= csr_pwdata[ihrg_pkg::COUNT_W-1:0];
            ihrg_pkg::REG_BOND_COUNT: cfg_ff.bond_count <= csr_pwdata[ihrg_pkg::COUNT_W-1:0];
            ihrg_pkg::REG_BOND_LOW:   cfg_ff.bond_table_low  <= csr_pwdata;
            ihrg_pkg::REG_BOND_HIGH:  cfg_ff.bond_table_high <= csr_pwdata;
            ihrg_pkg::REG_COUPLING_J: cfg_ff.coupling_j <= signed'(csr_pwdata[31:0]);
            ihrg_pkg::REG_FIELD_H:    cfg_ff.field_h    <= signed'(csr_pwdata[31:0]);
            ihrg_pkg::REG_BOUNDARY:   cfg_ff.boundary_field_on <= csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (index)
         ihrg_pkg::REG_NUM_SITES:  csr_prdata = 64'(cfg_ff.num_sites);
         ihrg_pkg::REG_BOND_COUNT: csr_prdata = 64'(cfg_ff.bond_count);
         ihrg_pkg::REG_BOND_LOW:   csr_prdata = cfg_ff.bond_table_low;
         ihrg_pkg::REG_BOND_HIGH:  csr_prdata = cfg_ff.bond_table_high;
         ihrg_pkg::REG_COUPLING_J: csr_prdata = {32'd0, cfg_ff.coupling_j};
         ihrg_pkg::REG_FIELD_H:    csr_prdata = {32'd0, cfg_ff.field_h};
         ihrg_pkg::REG_BOUNDARY:   csr_prdata = 64'(cfg_ff.boundary_field_on);
         default:                  csr_prdata = '0;
      endcase
   end

endmodule

`default_nettype wire

// ===== rtl/ihrg_front.sv =====
`default_nettype none

module ihrg_front (
   input  logic                            clock,
   input  logic                            reset,
   input  ihrg_pkg::cfg_type               cfg,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [ihrg_pkg::STATE_W-1:0]    req_tdata,
   output logic                            push,
   output ihrg_pkg::job_type               job,
   input  ihrg_pkg::qstat_type             qstat
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_BONDS,
      ST_MULT,
      ST_PUSH
   } state_type;

   state_type                              state_ff;
   logic [ihrg_pkg::STATE_W-1:0]           st_ff;
   logic [ihrg_pkg::COUNT_W-1:0]           bond_ff;
   logic signed [ihrg_pkg::COEF_W-1:0]     acc_ff;
   logic signed [ihrg_pkg::VALUE_W-1:0]    diag_ff;

   logic [ihrg_pkg::COUNT_W-1:0]           n_eff;
   logic [ihrg_pkg::COUNT_W-1:0]           nb_eff;
   logic [ihrg_pkg::STATE_W-1:0]           site_mask;
   logic [ihrg_pkg::STATE_W-1:0]           masked;
   logic [ihrg_pkg::SITE_W-1:0]            last_site;
   logic signed [ihrg_pkg::COEF_W-1:0]     boundary_term;
   logic [2*ihrg_pkg::TABLE_W-1:0]         table_bits;
   logic [7:0]                             bond_byte;
   logic signed [ihrg_pkg::COEF_W-1:0]     bond_term;
   logic signed [ihrg_pkg::PROD_W-1:0]     product;
   logic [ihrg_pkg::STATE_W-1:0]           pending;
   logic [ihrg_pkg::COUNT_W-1:0]           zeros;

   always_comb begin
      if (cfg.num_sites == '0)
         n_eff = ihrg_pkg::COUNT_W'(1);
      else if (cfg.num_sites > ihrg_pkg::COUNT_W'(ihrg_pkg::MAX_SITES))
         n_eff = ihrg_pkg::COUNT_W'(ihrg_pkg::MAX_SITES);
      else
         n_eff = cfg.num_sites;

      if (cfg.bond_count > ihrg_pkg::COUNT_W'(ihrg_pkg::MAX_BONDS))
         nb_eff = ihrg_pkg::COUNT_W'(ihrg_pkg::MAX_BONDS);
      else
         nb_eff = cfg.bond_count;

      for (int k = 0; k < ihrg_pkg::STATE_W; k++)
         site_mask[k] = (ihrg_pkg::COUNT_W'(k) < n_eff);
   end

   assign masked    = req_tdata & site_mask;
   assign last_site = ihrg_pkg::SITE_W'(n_eff - ihrg_pkg::COUNT_W'(1));

   // The accumulator holds minus the spin sum, so the product is the diagonal directly.
   always_comb begin
      if (!cfg.boundary_field_on)
         boundary_term = '0;
      else if (masked[0] && masked[last_site])
         boundary_term = -ihrg_pkg::COEF_W'(2);
      else if (!masked[0] && !masked[last_site])
         boundary_term = ihrg_pkg::COEF_W'(2);
      else
         boundary_term = '0;
   end

   assign table_bits = {cfg.bond_table_high, cfg.bond_table_low};
   assign bond_byte  = table_bits[{bond_ff[ihrg_pkg::SITE_W-1:0], 3'b000} +: 8];
   assign bond_term  = (st_ff[bond_byte[3:0]] == st_ff[bond_byte[7:4]])
                       ? -ihrg_pkg::COEF_W'(1) : ihrg_pkg::COEF_W'(1);

   assign product = ihrg_pkg::PROD_W'(acc_ff) * ihrg_pkg::PROD_W'(cfg.coupling_j);

   assign pending = ~st_ff & site_mask;

   always_comb begin
      zeros = ihrg_pkg::COUNT_W'(1);
      for (int k = 0; k < ihrg_pkg::STATE_W; k++)
         zeros = zeros + ihrg_pkg::COUNT_W'(pending[k]);
   end

   assign req_tready  = (state_ff == ST_IDLE);
   assign push        = (state_ff == ST_PUSH) && !qstat.full;
   assign job.state   = st_ff;
   assign job.pending = pending;
   assign job.diag    = diag_ff;
   assign job.count   = zeros;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (req_tvalid) begin
                  st_ff    <= masked;
                  acc_ff   <= boundary_term;
                  bond_ff  <= '0;
                  state_ff <= ST_BONDS;
               end
            end
            ST_BONDS: begin
               if (bond_ff == nb_eff) begin
                  state_ff <= ST_MULT;
               end else begin
                  acc_ff  <= acc_ff + bond_term;
                  bond_ff <= bond_ff + ihrg_pkg::COUNT_W'(1);
               end
            end
            ST_MULT: begin
               diag_ff  <= product[ihrg_pkg::VALUE_W-1:0];
               state_ff <= ST_PUSH;
            end
            ST_PUSH: begin
               if (!qstat.full)
                  state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

`default_nettype wire

// ===== rtl/ihrg_queue.sv =====
`default_nettype none

module ihrg_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  ihrg_pkg::job_type     push_job,
   input  logic                  pop,
   output ihrg_pkg::job_type     pop_job,
   output ihrg_pkg::qstat_type   qstat
);

   ihrg_pkg::job_type                    slot_ff [ihrg_pkg::QUEUE_DEPTH];
   logic [ihrg_pkg::QPTR_W-1:0]          wr_ptr_ff;
   logic [ihrg_pkg::QPTR_W-1:0]          rd_ptr_ff;
   logic [ihrg_pkg::QCNT_W-1:0]          count_ff;

   assign qstat.full  = (count_ff == ihrg_pkg::QCNT_W'(ihrg_pkg::QUEUE_DEPTH));
   assign qstat.empty = (count_ff == '0);
   assign pop_job     = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push)
         slot_ff[wr_ptr_ff] <= push_job;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            if (wr_ptr_ff == ihrg_pkg::QPTR_W'(ihrg_pkg::QUEUE_DEPTH - 1))
               wr_ptr_ff <= '0;
            else
               wr_ptr_ff <= wr_ptr_ff + ihrg_pkg::QPTR_W'(1);
         end
         if (pop) begin
            if (rd_ptr_ff == ihrg_pkg::QPTR_W'(ihrg_pkg::QUEUE_DEPTH - 1))
               rd_ptr_ff <= '0;
            else
               rd_ptr_ff <= rd_ptr_ff + ihrg_pkg::QPTR_W'(1);
         end
         if (push && !pop)
            count_ff <= count_ff + ihrg_pkg::QCNT_W'(1);
         else if (pop && !push)
            count_ff <= count_ff - ihrg_pkg::QCNT_W'(1);
      end
   end

endmodule

`default_nettype wire

// ===== rtl/ihrg_back.sv =====
`default_nettype none

module ihrg_back (
   input  logic                               clock,
   input  logic                               reset,
   input  ihrg_pkg::cfg_type                  cfg,
   input  ihrg_pkg::job_type                  job,
   input  ihrg_pkg::qstat_type                qstat,
   output logic                               pop,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [ihrg_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic                               rsp_tlast
);

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_DIAG,
      BK_OFF
   } state_type;

   state_type                              state_ff;
   logic [ihrg_pkg::STATE_W-1:0]           st_ff;
   logic [ihrg_pkg::STATE_W-1:0]           pend_ff;
   logic signed [ihrg_pkg::VALUE_W-1:0]    diag_ff;
   logic [ihrg_pkg::COUNT_W-1:0]           cnt_ff;

   logic                                   rsp_valid_ff;
   logic [ihrg_pkg::STATE_W-1:0]           rsp_col_ff;
   logic signed [ihrg_pkg::VALUE_W-1:0]    rsp_val_ff;
   logic [ihrg_pkg::COUNT_W-1:0]           rsp_cnt_ff;
   logic                                   rsp_last_ff;

   logic                                   slot_free;
   logic                                   emit;
   logic [ihrg_pkg::STATE_W-1:0]           low_bit;
   logic [ihrg_pkg::STATE_W-1:0]           pend_next;
   logic signed [ihrg_pkg::VALUE_W-1:0]    off_value;

   assign slot_free = !rsp_valid_ff || rsp_tready;
   assign emit      = slot_free && ((state_ff == BK_DIAG) || (state_ff == BK_OFF));
   assign pop       = (state_ff == BK_IDLE) && !qstat.empty;
   // Lowest flipped site still to go: isolate the lowest set bit of the pending mask.
   assign low_bit   = pend_ff & (~pend_ff + ihrg_pkg::STATE_W'(1));
   assign pend_next = pend_ff & ~low_bit;
   assign off_value = -ihrg_pkg::VALUE_W'(cfg.field_h);

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {(ihrg_pkg::RSP_DATA_W - ihrg_pkg::STATE_W - ihrg_pkg::VALUE_W
                         - ihrg_pkg::COUNT_W)'(0), rsp_cnt_ff, rsp_val_ff, rsp_col_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (emit)
            rsp_valid_ff <= 1'b1;
         else if (rsp_tready)
            rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            BK_IDLE: begin
               if (!qstat.empty) begin
                  st_ff    <= job.state;
                  pend_ff  <= job.pending;
                  diag_ff  <= job.diag;
                  cnt_ff   <= job.count;
                  state_ff <= BK_DIAG;
               end
            end
            BK_DIAG: begin
               if (slot_free) begin
                  rsp_col_ff   <= st_ff;
                  rsp_val_ff   <= diag_ff;
                  rsp_cnt_ff   <= cnt_ff;
                  rsp_last_ff  <= (pend_ff == '0);
                  state_ff     <= (pend_ff == '0) ? BK_IDLE : BK_OFF;
               end
            end
            BK_OFF: begin
               if (slot_free) begin
                  rsp_col_ff   <= st_ff | low_bit;
                  rsp_val_ff   <= off_value;
                  rsp_cnt_ff   <= cnt_ff;
                  rsp_last_ff  <= (pend_next == '0);
                  pend_ff      <= pend_next;
                  if (pend_next == '0)
                     state_ff <= BK_IDLE;
               end
            end
            default: state_ff <= BK_IDLE;
         endcase
      end
   end

endmodule

`default_nettype wire

// ===== rtl/ising_hamiltonian_row_generator.sv =====
// Ising Hamiltonian row generator.
// The req channel takes one basis state per word (req_tdata[15:0]). For each
// state the rsp channel returns the nonzero entries of its upper-triangle row
// in ascending column order: the diagonal first, then one transverse-field
// entry per clear site bit. rsp_tlast marks the final entry of a row.
// The front evaluates the bonds one per cycle and multiplies by J once; it
// accepts the next state only after the job of the last one enters the queue.
// A two-deep job queue feeds the back, which emits one entry per cycle while
// the receiver takes them; it starts the next job only after a row's last entry.
// When the receiver stalls, the output register holds its word, the back
// waits, the queue fills and req_tready eventually drops; nothing is lost.
// Synchronous reset empties the queue, idles both halves and loads the register
// defaults (16 sites, no bonds, J = 1.0, h = 0, boundary term off). Registers
// must be written through the APB-style port only while idle (not enforced).
`default_nettype none
`include "assert_macros.svh"

module ising_hamiltonian_row_generator (
   input  logic                               clock,
   input  logic                               reset,
   // req_tdata: basis_state[15:0]
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [ihrg_pkg::STATE_W-1:0]       req_tdata,
   // rsp_tdata: column[15:0], entry_value[52:16], row_entries[57:53], zero[63:58]
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [ihrg_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic                               rsp_tlast,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [ihrg_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [ihrg_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [ihrg_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                               csr_pready
);

   ihrg_pkg::cfg_type     cfg;
   ihrg_pkg::job_type     push_job;
   ihrg_pkg::job_type     pop_job;
   ihrg_pkg::qstat_type   qstat;
   logic                  push;
   logic                  pop;

   ihrg_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   ihrg_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .push       (push),
      .job        (push_job),
      .qstat      (qstat)
   );

   ihrg_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .pop_job  (pop_job),
      .qstat    (qstat)
   );

   ihrg_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .job        (pop_job),
      .qstat      (qstat),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   // The queue never takes a job when full nor gives one when empty.
   `ASSERT_IMPLIES(a_no_overflow, clock, reset, push, !qstat.full)
   `ASSERT_IMPLIES(a_no_underflow, clock, reset, pop, !qstat.empty)
   // A job entering an empty queue is visible to the back in the next cycle.
   `ASSERT_NEXT(a_push_seen, clock, reset, push && qstat.empty, !qstat.empty)

endmodule

`default_nettype wire

// ===== dv/ihrg_row_checker.sv =====
`timescale 1ns / 100ps

// Watches the register port and both streams, keeps its own copy of the
// register file and works out the row that each accepted basis state must
// produce. Every returned word is compared with the oldest expected entry.
module ihrg_row_checker
   import ihrg_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   input  logic                    req_tready,
   input  logic [STATE_W-1:0]      req_tdata,
   input  logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   input  logic [RSP_DATA_W-1:0]   rsp_tdata,
   input  logic                    rsp_tlast,
   input  logic                    csr_psel,
   input  logic                    csr_penable,
   input  logic                    csr_pwrite,
   input  logic                    csr_pready,
   input  logic [CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [CSR_DATA_W-1:0]   csr_pwdata,
   output int                      error_count,
   output int                      pending_count,
   output int                      row_count,
   output int                      entry_count
);

   localparam int PRINT_LIMIT = 40;

   typedef struct packed {
      logic [STATE_W-1:0]  column;
      logic [VALUE_W-1:0]  value;
      logic [COUNT_W-1:0]  row_entries;
      logic                last_entry;
   } matrix_entry_type;

   cfg_type          shadow_cfg;
   matrix_entry_type row_entry_q[$];

   function automatic int spin_of_site(input logic [STATE_W-1:0] st, input int unsigned k);
      return st[k] ? 1 : -1;
   endfunction

   // Appends the expected upper-triangle row of one basis state.
   function automatic void predict_row(input logic [STATE_W-1:0] raw_state);
      int unsigned      sites;
      int unsigned      bonds;
      int unsigned      k;
      int unsigned      seen;
      logic [7:0]       bond_byte;
      logic [STATE_W-1:0] st;
      int               coef;
      longint           diag;
      longint           off_value;
      logic [COUNT_W-1:0] cnt;
      matrix_entry_type ent;

      sites = shadow_cfg.num_sites;
      if (sites < 1) sites = 1;
      if (sites > MAX_SITES) sites = MAX_SITES;
      bonds = shadow_cfg.bond_count;
      if (bonds > MAX_BONDS) bonds = MAX_BONDS;

      st = raw_state & STATE_W'((32'd1 << sites) - 1);

      // Sites named beyond the cluster read a masked bit, hence spin down.
      coef = 0;
      for (k = 0; k < bonds; k++) begin
         bond_byte = (k < 8) ? shadow_cfg.bond_table_low[k*8 +: 8]
                             : shadow_cfg.bond_table_high[(k-8)*8 +: 8];
         coef += spin_of_site(st, bond_byte[3:0]) * spin_of_site(st, bond_byte[7:4]);
      end
      if (shadow_cfg.boundary_field_on)
         coef += spin_of_site(st, 0) + spin_of_site(st, sites - 1);

      diag      = -longint'(coef) * longint'($signed(shadow_cfg.coupling_j));
      off_value = -longint'($signed(shadow_cfg.field_h));

      cnt = 1;
      for (k = 0; k < sites; k++)
         if (!st[k]) cnt++;

      ent.column      = st;
      ent.value       = diag[VALUE_W-1:0];
      ent.row_entries = cnt;
      ent.last_entry  = (cnt == 1);
      row_entry_q.insert(row_entry_q.size(), ent);

      seen = 1;
      for (k = 0; k < sites; k++) begin
         if (!st[k]) begin
            ent.column      = st | STATE_W'(1 << k);
            ent.value       = off_value[VALUE_W-1:0];
            ent.row_entries = cnt;
            ent.last_entry  = (seen + 1 == cnt);
            row_entry_q.insert(row_entry_q.size(), ent);
            seen++;
         end
      end
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      if (error_count < PRINT_LIMIT)
         $display("%0t ns: %s mismatch: got 0x%0h, expected 0x%0h", $time, what, got, want);
      error_count++;
   endtask

   always @(posedge clock) begin
      matrix_entry_type want;
      if (reset) begin
         shadow_cfg.num_sites         = 5'd16;
         shadow_cfg.bond_count        = '0;
         shadow_cfg.bond_table_low    = '0;
         shadow_cfg.bond_table_high   = '0;
         shadow_cfg.coupling_j        = 32'sd65536;
         shadow_cfg.field_h           = '0;
         shadow_cfg.boundary_field_on = 1'b0;
         row_entry_q.delete();
         pending_count = 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (reg_index_type'(csr_paddr[5:3]))
               REG_NUM_SITES:  shadow_cfg.num_sites         = csr_pwdata[COUNT_W-1:0];
               REG_BOND_COUNT: shadow_cfg.bond_count        = csr_pwdata[COUNT_W-1:0];
               REG_BOND_LOW:   shadow_cfg.bond_table_low    = csr_pwdata;
               REG_BOND_HIGH:  shadow_cfg.bond_table_high   = csr_pwdata;
               REG_COUPLING_J: shadow_cfg.coupling_j        = csr_pwdata[31:0];
               REG_FIELD_H:    shadow_cfg.field_h           = csr_pwdata[31:0];
               REG_BOUNDARY:   shadow_cfg.boundary_field_on = csr_pwdata[0];
               default: ;
            endcase
         end

         // Results are taken before new requests so that a stray word can
         // never be matched against a row accepted on the same edge.
         if (rsp_tvalid && rsp_tready) begin
            entry_count++;
            if (row_entry_q.size() == 0) begin
               report_mismatch("word with no row pending", rsp_tdata, '0);
            end else begin
               want = row_entry_q.pop_front();
               if (rsp_tdata[15:0] !== want.column)
                  report_mismatch("column", rsp_tdata[15:0], want.column);
               if (rsp_tdata[52:16] !== want.value)
                  report_mismatch("entry value", rsp_tdata[52:16], want.value);
               if (rsp_tdata[57:53] !== want.row_entries)
                  report_mismatch("row entry count", rsp_tdata[57:53], want.row_entries);
               if (rsp_tlast !== want.last_entry)
                  report_mismatch("last entry flag", rsp_tlast, want.last_entry);
            end
         end

         if (req_tvalid && req_tready) begin
            predict_row(req_tdata);
            row_count++;
         end
         pending_count = row_entry_q.size();
      end
   end

endmodule

// ===== dv/ising_hamiltonian_row_generator_tb.sv =====
`timescale 1ns / 100ps

module ising_hamiltonian_row_generator_tb;
   import ihrg_pkg::*;

   localparam int          IDLE_LIMIT   = 3000;
   localparam int          HOLD_CYCLES  = 300;
   localparam int          RANDOM_ROUNDS = 8;
   localparam int          ROUND_STATES = 48;
   localparam logic [2:0]  UNUSED_REG   = 3'd7;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [STATE_W-1:0]      req_tdata = '0;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]   rsp_tdata;
   logic                    rsp_tlast;
   logic                    csr_psel = 1'b0;
   logic                    csr_penable = 1'b0;
   logic                    csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0]   csr_paddr = '0;
   logic [CSR_DATA_W-1:0]   csr_pwdata = '0;
   logic [CSR_DATA_W-1:0]   csr_prdata;
   logic                    csr_pready;

   int error_count;
   int pending_count;
   int row_count;
   int entry_count;
   int settings_count = 0;
   bit no_idle = 1'b0;
   bit hold_off_request = 1'b0;

   ising_hamiltonian_row_generator u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   ihrg_row_checker u_row_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tlast     (rsp_tlast),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_pready    (csr_pready),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .error_count   (error_count),
      .pending_count (pending_count),
      .row_count     (row_count),
      .entry_count   (entry_count)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // Mostly no gap, sometimes a short one and now and then a long one.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      else if (r < 90) return $urandom_range(1, 3);
      else return $urandom_range(10, 40);
   endfunction

   task automatic csr_write(input logic [2:0] index, input logic [CSR_DATA_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {index, 3'b000};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic load_settings(input logic [4:0] sites, input logic [4:0] bonds,
                                input logic [63:0] bond_lo, input logic [63:0] bond_hi,
                                input logic [31:0] coupling, input logic [31:0] field,
                                input logic boundary);
      csr_write(REG_NUM_SITES, 64'(sites));
      csr_write(REG_BOND_COUNT, 64'(bonds));
      csr_write(REG_BOND_LOW, bond_lo);
      csr_write(REG_BOND_HIGH, bond_hi);
      csr_write(REG_COUPLING_J, 64'(coupling));
      csr_write(REG_FIELD_H, 64'(field));
      csr_write(REG_BOUNDARY, 64'(boundary));
      settings_count++;
   endtask

   function automatic logic [31:0] pick_q16();
      case ($urandom_range(0, 7))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return 32'h0001_0000;
         default: return $urandom();
      endcase
   endfunction

   task automatic load_random_settings();
      logic [4:0] sites;
      logic [4:0] bonds;
      case ($urandom_range(0, 9))
         0: sites = 5'd16;
         1: sites = 5'd1;
         2: sites = 5'($urandom_range(0, 31));
         default: sites = 5'($urandom_range(1, 16));
      endcase
      bonds = ($urandom_range(0, 4) == 0) ? 5'd16 : 5'($urandom_range(0, 31));
      load_settings(sites, bonds, {$urandom(), $urandom()}, {$urandom(), $urandom()},
                    pick_q16(), pick_q16(), 1'($urandom_range(0, 1)));
   endtask

   task automatic send_state(input logic [STATE_W-1:0] st);
      int gap;
      gap = no_idle ? 0 : pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= st;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // Stops offering words and waits until every expected entry has come back.
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   function automatic logic [STATE_W-1:0] pick_state();
      case ($urandom_range(0, 6))
         0: return STATE_W'($urandom() | $urandom());
         1: return STATE_W'($urandom() & $urandom() & $urandom());
         default: return STATE_W'($urandom_range(0, 65535));
      endcase
   endfunction

   // Result side: random back-pressure, plus one long hold-off on request.
   initial begin
      int gap;
      @(posedge clock);
      forever begin
         if (hold_off_request) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_off_request = 1'b0;
         end else begin
            gap = no_idle ? 0 : pick_gap();
            if (gap == 0) begin
               rsp_tready <= 1'b1;
               @(posedge clock);
            end else begin
               rsp_tready <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
      end
   end

   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("ising_hamiltonian_row_generator test failed");
      $finish;
   end

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Register defaults: sixteen sites, no bonds, no field.
      send_state(16'h0000);
      send_state(16'hFFFF);
      send_state(16'h8001);
      drain();

      // Closed chain over all sites with full-scale coupling and field.
      load_settings(5'd16, 5'd16, 64'h8776_6554_4332_2110, 64'h0FFE_EDDC_CBBA_A998,
                    32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
      send_state(16'h0000);
      send_state(16'hFFFF);
      send_state(16'hAAAA);
      send_state(16'h5555);
      drain();
      load_settings(5'd16, 5'd16, 64'h8776_6554_4332_2110, 64'h0FFE_EDDC_CBBA_A998,
                    32'h8000_0000, 32'h7FFF_FFFF, 1'b1);
      send_state(16'h0000);
      send_state(16'hFFFF);
      send_state(16'h0001);
      send_state(16'h8000);
      drain();

      // Four sites, a bond count past the table and bonds naming absent sites;
      // high state bits must be masked away.
      load_settings(5'd4, 5'd31, 64'h0000_0000_0F93_3210, 64'hF0F0_F0F0_5A5A_5A5A,
                    32'hFFFF_0000, 32'h0002_8000, 1'b1);
      csr_write(UNUSED_REG, 64'hFFFF_FFFF_FFFF_FFFF);
      send_state(16'hFFFF);
      send_state(16'h0000);
      send_state(16'hFFF5);
      drain();

      // A site count of zero behaves as one site.
      csr_write(REG_NUM_SITES, 64'd0);
      send_state(16'hFFFF);
      send_state(16'hFFFE);
      drain();

      // A site count above the maximum behaves as sixteen.
      csr_write(REG_NUM_SITES, 64'd31);
      send_state(16'h1234);
      send_state(16'hEDCB);
      drain();

      for (int round = 0; round < RANDOM_ROUNDS; round++) begin
         load_random_settings();
         no_idle = (round == 5);
         for (int i = 0; i < ROUND_STATES; i++) begin
            // Hold the result side off while words keep arriving, so that the
            // job queue fills and the input stalls.
            if (round == 3 && i == 5)
               hold_off_request = 1'b1;
            send_state(pick_state());
         end
         drain();
      end
      no_idle = 1'b0;

      repeat (40) @(posedge clock);

      $display("Checked %0d basis states and %0d matrix entries across %0d register settings.",
               row_count, entry_count, settings_count);
      $display("Covered clamping, absent bond sites, full-scale J and h and a %0d-cycle stall.",
               HOLD_CYCLES);
      if (error_count == 0)
         $display("ising_hamiltonian_row_generator test passed");
      else
         $display("ising_hamiltonian_row_generator test failed");
      $finish;
   end

endmodule
